// File: hw/rtl/qvs_pkg.sv
// Shared types and constants for the quadrature velocity sampler.
// Holds the port words, controller/datapath command and status, and the step table.
// No dependencies.
`timescale 1ns / 1ps

package qvs_pkg;

    localparam int NUM_ENCODERS = 3;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [15:0] X_COEF     = 16'd59310;
    localparam logic [15:0] Y_COEF     = 16'd59578;

    typedef struct packed {
        logic       command;
        logic [1:0] encoder_select;
        logic       level_a;
        logic       level_b;
    } in_word_t;

    typedef struct packed {
        logic [15:0] wheel_speed_one;
        logic [15:0] wheel_speed_two;
        logic [15:0] wheel_speed_three;
        logic [16:0] body_speed_x;
        logic [24:0] body_speed_y;
        logic [17:0] speed_sum;
    } out_word_t;

    typedef enum logic [1:0] {
        DIR_HOLD,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    // Index is {previous A, previous B, new A, new B}.
    localparam dir_t STEP_TABLE [16] = '{
        DIR_HOLD, DIR_DOWN, DIR_UP,   DIR_HOLD,
        DIR_UP,   DIR_HOLD, DIR_HOLD, DIR_DOWN,
        DIR_DOWN, DIR_HOLD, DIR_HOLD, DIR_UP,
        DIR_HOLD, DIR_UP,   DIR_DOWN, DIR_HOLD
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROD,
        S_SPLIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic edge_en;
        logic sample_en;
        logic prod_en;
        logic split_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// File: hw/rtl/qvs_ctrl.sv
// Sequencer for the quadrature velocity sampler.
// Steps a sample word through product, split and finish; depends on qvs_pkg.
`timescale 1ns / 1ps

module qvs_ctrl
    import qvs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   command,
    output logic   in_stall,
    output cmd_t   cmd,
    input  stat_t  stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && command)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.edge_en   = in_valid && !command;
                cmd.sample_en = in_valid && command;
            end
            S_PROD:
            begin
                cmd.prod_en = 1'b1;
            end
            S_SPLIT:
            begin
                cmd.split_en = 1'b1;
            end
            S_FINISH:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sample_en |=> in_stall && cmd.prod_en)
        else $error("sample word did not start the product step");

    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> $past(state_reg) == S_PROD)
        else $error("split step entered out of order");

endmodule

// File: hw/rtl/qvs_datapath.sv
// Counters, speed arithmetic and output register of the quadrature velocity sampler.
// Driven by qvs_ctrl commands; depends on qvs_pkg.
`timescale 1ns / 1ps

module qvs_datapath
    import qvs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_word_t    in_word,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word
);

    localparam int CW = COUNT_WIDTH;
    localparam int SW = ((CW > 16) ? CW : 16) + 2;
    localparam int MW = SW + 16;
    localparam int QW = SW + 8;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic [1:0]    prev_reg [NUM_ENCODERS];
    logic [1:0]    prev_next [NUM_ENCODERS];
    logic [CW-1:0] cnt_reg [NUM_ENCODERS];
    logic [CW-1:0] cnt_next [NUM_ENCODERS];
    logic [15:0]   gain_reg;
    logic [15:0]   gain_next;

    logic [15:0]   wheel_reg [NUM_ENCODERS];
    logic [17:0]   sum_reg;
    logic [SW-1:0] ax_reg;
    logic          nx_reg;
    logic [SW-1:0] ay_reg;
    logic          ny_reg;
    logic [MW-1:0] mx_reg;
    logic [MW-1:0] my_reg;
    logic [16:0]   x17_reg;
    logic          ny2_reg;
    logic [QW-1:0] phi_reg;
    logic [15:0]   plo_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    out_word_t     out_word_reg;

    logic [SW-1:0] ext [NUM_ENCODERS];
    logic [SW-1:0] dx;
    logic [SW-1:0] dy;
    logic [SW-1:0] sum_full;
    logic [1:0]    lv;
    dir_t          dir;
    logic [MW-1:0] rx;
    logic [MW-1:0] xs;
    logic [39:0]   lo_prod;
    logic [QW-1:0] ry;
    logic [QW-1:0] ys;

    assign lv = {in_word.level_a, in_word.level_b};

    // Edge counting: one encoder per word, saturating.
    always_comb
    begin
        dir = DIR_HOLD;
        for (int i = 0; i < NUM_ENCODERS; i++)
        begin
            prev_next[i] = prev_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (cmd.sample_en)
            begin
                cnt_next[i] = '0;
            end
            else if (cmd.edge_en && (in_word.encoder_select == 2'(i)))
            begin
                prev_next[i] = lv;
                dir          = STEP_TABLE[{prev_reg[i], lv}];
                case (dir)
                    DIR_UP:
                    begin
                        if (cnt_reg[i] != CMAX)
                        begin
                            cnt_next[i] = cnt_reg[i] + CW'(1);
                        end
                    end
                    DIR_DOWN:
                    begin
                        if (cnt_reg[i] != CMIN)
                        begin
                            cnt_next[i] = cnt_reg[i] - CW'(1);
                        end
                    end
                    default:
                    begin
                        cnt_next[i] = cnt_reg[i];
                    end
                endcase
            end
        end
    end

    assign gain_next = cfg_valid ? cfg_data : gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                prev_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                prev_reg[i] <= prev_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Latch: sign-extend counts, form differences and the sum.
    always_comb
    begin
        for (int i = 0; i < NUM_ENCODERS; i++)
        begin
            ext[i] = {{(SW-CW){cnt_reg[i][CW-1]}}, cnt_reg[i]};
        end
        dx       = (ext[2] << 1) - ext[0] - ext[1];
        dy       = ext[1] - ext[0];
        sum_full = ext[0] + ext[1] + ext[2];
    end

    // Split: scale X, cut the Y product into high and low partial products.
    always_comb
    begin
        rx      = mx_reg >> 17;
        xs      = nx_reg ? (~rx + MW'(1)) : rx;
        lo_prod = 40'(my_reg[23:0]) * 40'(Y_COEF);
    end

    // Finish: join Y partial products and restore sign.
    always_comb
    begin
        ry = phi_reg + QW'(plo_reg);
        ys = ny2_reg ? (~ry + QW'(1)) : ry;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_en)
        begin
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                wheel_reg[i] <= ext[i][15:0];
            end
            sum_reg <= sum_full[17:0];
            nx_reg  <= dx[SW-1];
            ax_reg  <= dx[SW-1] ? (~dx + SW'(1)) : dx;
            ny_reg  <= dy[SW-1];
            ay_reg  <= dy[SW-1] ? (~dy + SW'(1)) : dy;
        end
        if (cmd.prod_en)
        begin
            mx_reg <= MW'(ax_reg) * MW'(X_COEF);
            my_reg <= MW'(ay_reg) * MW'(gain_reg);
        end
        if (cmd.split_en)
        begin
            x17_reg <= xs[16:0];
            ny2_reg <= ny_reg;
            phi_reg <= QW'(my_reg[MW-1:24]) * QW'(Y_COEF);
            plo_reg <= lo_prod[39:24];
        end
        if (cmd.load_out)
        begin
            out_word_reg.wheel_speed_one   <= wheel_reg[0];
            out_word_reg.wheel_speed_two   <= wheel_reg[1];
            out_word_reg.wheel_speed_three <= wheel_reg[2];
            out_word_reg.body_speed_x      <= x17_reg;
            out_word_reg.body_speed_y      <= ys[24:0];
            out_word_reg.speed_sum         <= sum_reg;
        end
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;

    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sample_en |=> (cnt_reg[0] == '0) && (cnt_reg[1] == '0) && (cnt_reg[2] == '0))
        else $error("counters not cleared by sample");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("output valid without a load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

endmodule

// File: hw/rtl/quadrature_velocity_sampler_top.sv
// Top level of the three-encoder quadrature velocity sampler.
// Instantiates qvs_ctrl and qvs_datapath; depends on qvs_pkg.
`timescale 1ns / 1ps

// An edge word (command 0) updates one encoder's x4 count in the cycle it is
// accepted and yields no result; encoder select three is dropped. A sample
// word (command 1) latches and clears the counts, then passes through the
// multiply, split and finish steps before the result word is loaded into the
// output register; no further word is taken until that load is done. Edge
// words keep flowing while a result waits in the output register; a sample
// waits in its finish step until that register is free. The gain register may
// be written at any cycle while the block is idle.
module quadrature_velocity_sampler_top
    import qvs_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    qvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (in_word.command),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    qvs_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// File: verif/quadrature_velocity_sampler_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_velocity_sampler_top: directed, long-run and
// random edge/sample words, scored against an independent x4 decoder and speed model.
// Depends on qvs_pkg and the sampler RTL; needs no files or arguments.

module quadrature_velocity_sampler_top_tb;
    import qvs_pkg::*;

    localparam int         COUNT_WIDTH   = 16;
    localparam longint     COUNT_MAX     = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
    localparam longint     COUNT_MIN     = -COUNT_MAX - 1;
    localparam logic       CMD_EDGE      = 1'b0;
    localparam logic       CMD_SAMPLE    = 1'b1;
    localparam logic [1:0] SEL_NONE      = 2'(NUM_ENCODERS);
    localparam int         CLK_PERIOD    = 10;
    localparam int         MAX_REPORTS   = 10;
    localparam int         LONG_HOLD     = 400;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         RUN_STEPS     = 100;
    localparam int         PHASE_WORDS   = 170;
    localparam int         NUM_PHASES    = 8;
    localparam longint     TIMEOUT_NS    = 64'd20_000_000;

    class speed_scoreboard;
        logic [1:0]  levels [NUM_ENCODERS];
        longint      counts [NUM_ENCODERS];
        logic [15:0] gain;
        out_word_t   pending_speeds [$];
        int          errors;
        int          edges_seen;
        int          samples_seen;
        int          results_checked;

        function new();
            foreach (levels[i])
            begin
                levels[i] = 2'b00;
                counts[i] = 0;
            end
            gain            = GAIN_RESET;
            errors          = 0;
            edges_seen      = 0;
            samples_seen    = 0;
            results_checked = 0;
        endfunction

        static function logic [1:0] step_up(input logic [1:0] lv);
            return {~lv[0], lv[1]};
        endfunction

        static function logic [1:0] step_down(input logic [1:0] lv);
            return {lv[0], ~lv[1]};
        endfunction

        function logic [16:0] body_x_of(input longint s1, input longint s2, input longint s3);
            longint d;
            longint r;
            d = 2 * s3 - s1 - s2;
            r = ((d < 0 ? -d : d) * longint'(X_COEF)) >> 17;
            return 17'(d < 0 ? -r : r);
        endfunction

        function logic [24:0] body_y_of(input longint s1, input longint s2);
            longint d;
            longint m;
            longint r;
            d = s2 - s1;
            m = (d < 0 ? -d : d) * longint'(gain);
            r = (m >> 24) * longint'(Y_COEF) + (((m & 64'hFF_FFFF) * longint'(Y_COEF)) >> 24);
            return 25'(d < 0 ? -r : r);
        endfunction

        function void flag(input string what, input string detail);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] MISMATCH %s: %s", $time, what, detail);
        endfunction

        function void note_word(input in_word_t w);
            logic [1:0] lv;
            int         sel;
            longint     s1;
            longint     s2;
            longint     s3;
            out_word_t  speeds;
            if (w.command == CMD_SAMPLE)
            begin
                s1 = counts[0];
                s2 = counts[1];
                s3 = counts[2];
                foreach (counts[i])
                    counts[i] = 0;
                speeds.wheel_speed_one   = 16'(s1);
                speeds.wheel_speed_two   = 16'(s2);
                speeds.wheel_speed_three = 16'(s3);
                speeds.body_speed_x      = body_x_of(s1, s2, s3);
                speeds.body_speed_y      = body_y_of(s1, s2);
                speeds.speed_sum         = 18'(s1 + s2 + s3);
                pending_speeds.push_back(speeds);
                samples_seen++;
            end
            else if (w.encoder_select < SEL_NONE)
            begin
                sel = int'(w.encoder_select);
                lv  = {w.level_a, w.level_b};
                if (lv == step_up(levels[sel]) && counts[sel] < COUNT_MAX)
                    counts[sel]++;
                else if (lv == step_down(levels[sel]) && counts[sel] > COUNT_MIN)
                    counts[sel]--;
                levels[sel] = lv;
                edges_seen++;
            end
        endfunction

        function void compare(input string name, input logic [24:0] want, input logic [24:0] got);
            if (got !== want)
                flag(name, $sformatf("expected %0h got %0h", want, got));
        endfunction

        function void check_word(input out_word_t got);
            out_word_t want;
            if (pending_speeds.size() == 0)
            begin
                flag("result with nothing pending", $sformatf("got %h", got));
                return;
            end
            want = pending_speeds.pop_front();
            results_checked++;
            compare("wheel_speed_one", want.wheel_speed_one, got.wheel_speed_one);
            compare("wheel_speed_two", want.wheel_speed_two, got.wheel_speed_two);
            compare("wheel_speed_three", want.wheel_speed_three, got.wheel_speed_three);
            compare("body_speed_x", want.body_speed_x, got.body_speed_x);
            compare("body_speed_y", want.body_speed_y, got.body_speed_y);
            compare("speed_sum", want.speed_sum, got.speed_sum);
        endfunction

        function void close_out();
            if (pending_speeds.size() != 0)
                flag("results never delivered", $sformatf("%0d left", pending_speeds.size()));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    speed_scoreboard sb = new();

    bit          gaps_on;
    int          hold_requests;
    int          words_sent;
    int          gain_writes;
    bit          enc_up [NUM_ENCODERS];
    logic [1:0]  sent_levels [NUM_ENCODERS] = '{default: 2'b00};

    quadrature_velocity_sampler_top #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic send_word(input in_word_t w);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(w);
        words_sent++;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_edge(input int sel, input logic [1:0] lv);
        in_word_t w;
        w.command        = CMD_EDGE;
        w.encoder_select = 2'(sel);
        w.level_a        = lv[1];
        w.level_b        = lv[0];
        if (sel < NUM_ENCODERS)
            sent_levels[sel] = lv;
        send_word(w);
    endtask

    task automatic send_sample(input logic [1:0] sel_bits, input logic [1:0] lv);
        in_word_t w;
        w.command        = CMD_SAMPLE;
        w.encoder_select = sel_bits;
        w.level_a        = lv[1];
        w.level_b        = lv[0];
        send_word(w);
    endtask

    task automatic send_step(input int sel, input bit up);
        if (up)
            send_edge(sel, speed_scoreboard::step_up(sent_levels[sel]));
        else
            send_edge(sel, speed_scoreboard::step_down(sent_levels[sel]));
    endtask

    task automatic run_random(input int count, input int sample_pct);
        int pick;
        int sel;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, NUM_ENCODERS - 1);
            if ($urandom_range(0, 9) == 0)
                enc_up[sel] = ~enc_up[sel];
            if (pick < sample_pct)
                send_sample(2'($urandom), 2'($urandom));
            else if (pick < 80)
                send_step(sel, enc_up[sel]);
            else if (pick < 88)
                send_edge(sel, $urandom_range(0, 1) ? sent_levels[sel] : ~sent_levels[sel]);
            else if (pick < 93)
                send_edge(NUM_ENCODERS, 2'($urandom));
            else
                send_edge($urandom_range(0, 3), 2'($urandom));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_speeds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(input logic [15:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.gain = g;
        gain_writes++;
    endtask

    initial
    begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_word(out_word);
            if (hold_requests > holds_served)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        logic [15:0] phase_gain [NUM_PHASES];
        phase_gain    = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom), GAIN_RESET,
                          16'($urandom), 16'h8000, 16'($urandom)};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        hold_requests = 0;
        words_sent    = 0;
        gain_writes   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gain, every up and down code, holds, double steps, dropped select
        send_sample(2'b00, 2'b00);
        repeat (4) send_step(0, 1'b1);
        repeat (4) send_step(1, 1'b0);
        send_edge(2, 2'b11);
        send_edge(2, 2'b11);
        send_edge(2, 2'b00);
        send_step(2, 1'b0);
        send_edge(NUM_ENCODERS, 2'b11);
        send_sample(2'b11, 2'b11);
        send_sample(2'b00, 2'b00);
        send_edge(0, 2'b01);
        send_edge(0, 2'b10);
        send_step(1, 1'b1);
        send_step(2, 1'b1);
        send_step(2, 1'b1);
        send_sample(2'b10, 2'b01);
        settle();

        // long one-way runs on every counter, both directions, at full gain
        write_gain(16'hFFFF);
        gaps_on = 1'b0;
        repeat (RUN_STEPS)
        begin
            send_step(0, 1'b0);
            send_step(1, 1'b1);
            send_step(2, 1'b1);
        end
        send_sample(2'b00, 2'b00);
        repeat (RUN_STEPS)
        begin
            send_step(0, 1'b1);
            send_step(1, 1'b0);
            send_step(2, 1'b0);
        end
        send_sample(2'b00, 2'b00);
        gaps_on = 1'b1;
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_gain(phase_gain[p]);
            if (p == NUM_PHASES - 1)
                gaps_on = 1'b0;
            if (p == 2)
            begin
                hold_requests++;
                run_random(40, 50);
            end
            run_random(PHASE_WORDS, (p % 2) ? 3 : 8);
            settle();
        end

        sb.close_out();
        $display("Sent %0d words (%0d counted edges, %0d samples); checked %0d speed results.",
                 words_sent, sb.edges_seen, sb.samples_seen, sb.results_checked);
        $display("Covered %0d gain writes, long one-way count runs, a %0d-cycle output hold.",
                 gain_writes, LONG_HOLD);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Run timed out");
        $display("Test completed with failures");
        $finish;
    end

endmodule
